[rtl/tilt_pkg.sv]
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared constants, types and the arctangent table of the tilt pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tilt_pkg;

    // Sample and fixed-point layout.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_STEPS     = 28;
    localparam int ACC_WIDTH        = 33;

    // Angle to degree conversion: deg = floor(ang * 9000 / (157 * 2^30)).
    localparam logic [33:0] PI_Q30       = 34'd3373259426;
    localparam logic [13:0] DEG_NUM      = 14'd9000;
    localparam int          DEG_SHIFT    = 30;
    localparam logic [7:0]  DEG_MAX      = 8'd180;
    localparam logic [16:0] DEG_CLAMP_T  = 17'd28417;   // 181 * 157

    // Division by 157 as (t * 26716) >> 22, exact for t below 181 * 157.
    localparam logic [14:0] DEG_RECIP       = 15'd26716;
    localparam int          DEG_RECIP_SHIFT = 22;

    // Tens split: floor(deg / 10) == (deg * 205) >> 11 for deg up to 180.
    localparam logic [7:0]  TENS_MUL     = 8'd205;
    localparam int          TENS_SHIFT   = 11;
    localparam logic [6:0]  ASCII_ZERO   = 7'd48;

    // Flag byte fill and danger scaling.
    localparam logic [4:0]  FLAG_FILL    = 5'b11111;
    localparam logic [10:0] DANGER_NUM   = 11'd1521;
    localparam logic [19:0] DANGER_SCALE = 20'd1000000;
    localparam int          LIM_WIDTH    = 36;
    localparam logic [7:0]  LIMIT_RESET  = 8'd15;

    // Data that rides along with each item through the long stages.
    typedef struct packed {
        logic [2:0] flags;     // bit i: axis i non-negative
        logic       danger;
        logic       zero;      // all three axes zero
    } side_t;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        begin
            unique case (i)
                0:  v = 30'h3243F6A8;
                1:  v = 30'h1DAC6705;
                2:  v = 30'h0FADBAFC;
                3:  v = 30'h07F56EA6;
                4:  v = 30'h03FEAB76;
                5:  v = 30'h01FFD55B;
                6:  v = 30'h00FFFAAA;
                7:  v = 30'h007FFF55;
                8:  v = 30'h003FFFEA;
                9:  v = 30'h001FFFFD;
                10: v = 30'h000FFFFF;
                11: v = 30'h0007FFFF;
                12: v = 30'h0003FFFF;
                13: v = 30'h0001FFFF;
                14: v = 30'h0000FFFF;
                15: v = 30'h00007FFF;
                16: v = 30'h00003FFF;
                17: v = 30'h00001FFF;
                18: v = 30'h00000FFF;
                19: v = 30'h000007FF;
                20: v = 30'h000003FF;
                21: v = 30'h000001FF;
                22: v = 30'h000000FF;
                23: v = 30'h0000007F;
                24: v = 30'h0000003F;
                25: v = 30'h0000001F;
                26: v = 30'h0000000F;
                27: v = 30'h00000007;
                default: v = 30'h0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/tilt_isqrt.sv]
// ----------------------------------------------------------------------------
// tilt_isqrt
// Pipelined square root of (x^2 + y^2) * 2^32, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_isqrt
    import tilt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [2*SAMPLE_WIDTH-1:0]        in_pl,
    input  wire logic [SAMPLE_WIDTH-1:0]          in_absz,
    input  wire side_t                            in_side,
    output logic                                  out_valid,
    output logic [SAMPLE_WIDTH+FRAC_BITS-1:0]     out_root,
    output logic [SAMPLE_WIDTH-1:0]               out_absz,
    output side_t                                 out_side
);

    localparam int RW  = SAMPLE_WIDTH + FRAC_BITS;
    localparam int RMW = RW + 2;

    logic                   valid_reg [0:RW];
    logic [RMW-1:0]         rem_reg   [0:RW];
    logic [RW-1:0]          root_reg  [0:RW];
    logic [2*SAMPLE_WIDTH-1:0] pl_reg [0:RW];
    logic [SAMPLE_WIDTH-1:0] absz_reg [0:RW];
    side_t                  side_reg  [0:RW];

    // Stage zero is the module input.
    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = '0;
        root_reg[0]  = '0;
        pl_reg[0]    = in_pl;
        absz_reg[0]  = in_absz;
        side_reg[0]  = in_side;
    end

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [1:0]     pair;
        logic [RMW+1:0] cur;
        logic [RMW+1:0] trial;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        // Next two radicand bits; the low 32 radicand bits are zero.
        if (k < SAMPLE_WIDTH) begin : g_pair
            assign pair = pl_reg[k][2*SAMPLE_WIDTH-1-2*k -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        // One restoring root digit.
        always_comb
        begin
            cur   = {rem_reg[k], pair};
            trial = {2'b00, root_reg[k], 2'b01};
            if (cur >= trial)
            begin
                rem_next  = RMW'(cur - trial);
                root_next = {root_reg[k][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RMW'(cur);
                root_next = {root_reg[k][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                pl_reg[k+1]   <= pl_reg[k];
                absz_reg[k+1] <= absz_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_absz  = absz_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

`default_nettype wire

[rtl/tilt_cordic.sv]
// ----------------------------------------------------------------------------
// tilt_cordic
// Pipelined CORDIC vectoring, one micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_cordic
    import tilt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [SAMPLE_WIDTH+FRAC_BITS-1:0]    in_root,
    input  wire logic [SAMPLE_WIDTH-1:0]              in_absz,
    input  wire side_t                                in_side,
    output logic                                      out_valid,
    output logic signed [ACC_WIDTH-1:0]               out_acc,
    output side_t                                     out_side
);

    localparam int RW = SAMPLE_WIDTH + FRAC_BITS;
    localparam int CW = RW + 3;

    logic                        valid_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0]        vx_reg    [0:CORDIC_STEPS];
    logic signed [CW-1:0]        vy_reg    [0:CORDIC_STEPS];
    logic signed [ACC_WIDTH-1:0] acc_reg   [0:CORDIC_STEPS];
    side_t                       side_reg  [0:CORDIC_STEPS];

    // Start vector: (|z| * 2^16, rho).
    always_comb
    begin
        valid_reg[0] = in_valid;
        vx_reg[0]    = $signed({3'b000, in_absz, {FRAC_BITS{1'b0}}});
        vy_reg[0]    = $signed({3'b000, in_root});
        acc_reg[0]   = '0;
        side_reg[0]  = in_side;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [CW-1:0]        vx_next;
        logic signed [CW-1:0]        vy_next;
        logic signed [ACC_WIDTH-1:0] acc_next;
        logic signed [ACC_WIDTH-1:0] step_ang;

        // Rotate toward the x axis and accumulate the angle.
        always_comb
        begin
            step_ang = $signed({{(ACC_WIDTH-30){1'b0}}, atan_q30(i)});
            if (vy_reg[i] >= 0)
            begin
                vx_next  = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next  = vy_reg[i] - (vx_reg[i] >>> i);
                acc_next = acc_reg[i] + step_ang;
            end
            else
            begin
                vx_next  = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next  = vy_reg[i] + (vx_reg[i] >>> i);
                acc_next = acc_reg[i] - step_ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vx_reg[i+1]   <= vx_next;
                vy_reg[i+1]   <= vy_next;
                acc_reg[i+1]  <= acc_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_acc   = acc_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

[rtl/tilt_deg.sv]
// ----------------------------------------------------------------------------
// tilt_deg
// Turns the CORDIC angle into whole degrees and two digit characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_deg
    import tilt_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [ACC_WIDTH-1:0]   in_acc,
    input  wire side_t                         in_side,
    output logic                               out_valid,
    output side_t                              out_side,
    output logic [6:0]                         out_tens,
    output logic [5:0]                         out_ones
);

    // Stage 1: fold for negative z and test for a positive angle.
    logic [3:0]         valid_reg;
    side_t              side1_reg, side2_reg, side3_reg, side4_reg;
    logic               pos1_reg, pos2_reg;
    logic [32:0]        ang1_reg;
    logic [46:0]        prod2_reg;
    logic [7:0]         deg3_reg;
    logic [6:0]         tens4_reg;
    logic [5:0]         ones4_reg;

    logic signed [34:0] ang_next;
    logic               pos_next;

    always_comb
    begin
        if (in_side.flags[2])
            ang_next = 35'(in_acc);
        else
            ang_next = $signed({1'b0, PI_Q30}) - 35'(in_acc);
        pos_next = !in_side.zero && (ang_next > 0);
    end

    // Stage 3: scale down, clamp and divide by 157 with a reciprocal product.
    logic [16:0] t_val;
    logic [31:0] q_prod;
    logic [7:0]  deg_next;

    always_comb
    begin
        t_val  = prod2_reg[46:DEG_SHIFT];
        q_prod = 32'(t_val) * 32'(DEG_RECIP);
        if (!pos2_reg)
            deg_next = '0;
        else if (t_val >= DEG_CLAMP_T)
            deg_next = DEG_MAX;
        else
            deg_next = q_prod[DEG_RECIP_SHIFT+7:DEG_RECIP_SHIFT];
    end

    // Stage 4: split into tens and ones characters.
    logic [15:0] tens_prod;
    logic [4:0]  tens_val;
    logic [7:0]  ones_val;

    always_comb
    begin
        tens_prod = deg3_reg * TENS_MUL;
        tens_val  = tens_prod[TENS_SHIFT+4:TENS_SHIFT];
        ones_val  = deg3_reg - 8'(8'(tens_val) * 8'd10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            pos1_reg  <= pos_next;
            ang1_reg  <= ang_next[32:0];
            side2_reg <= side1_reg;
            pos2_reg  <= pos1_reg;
            prod2_reg <= ang1_reg * DEG_NUM;
            side3_reg <= side2_reg;
            deg3_reg  <= deg_next;
            side4_reg <= side3_reg;
            tens4_reg <= 7'(tens_val) + ASCII_ZERO;
            ones4_reg <= 6'(ones_val[3:0]) + 6'(ASCII_ZERO);
        end
    end

    assign out_valid = valid_reg[3];
    assign out_side  = side4_reg;
    assign out_tens  = tens4_reg;
    assign out_ones  = ones4_reg;

endmodule

`default_nettype wire

[rtl/accel_tilt_angle_danger.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angle_danger
// Tilt angle and danger flag of one three-axis acceleration sample.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    tdata: accel_x, accel_y, accel_z
//  m_*       out        tvalid / tready    tdata: flags, tens, ones, danger
//  cfg_*     in         cfg_we             cfg_wdata: danger_limit
//
// One item enters per cycle while the stages move; the path holds four front
// stages, SAMPLE_WIDTH + 16 square root stages, 28 CORDIC stages, four degree
// stages and the output register. All stages move together; they hold only when
// the output register is full, unread, and a finished item waits behind it. Reset
// clears every valid bit and sets danger_limit to 15. A written limit reaches the
// danger compare through limit_reg, lim_sq_reg and lim_reg in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angle_danger
    import tilt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // sign_flags [7:0], tilt_tens_char [14:8],
                                        // tilt_ones_char [20:15], danger [21], zero [23:22]
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int RW   = SW + FRAC_BITS;
    localparam int PW   = 2*SW + 11;
    localparam int CMPW = (PW > LIM_WIDTH) ? PW : LIM_WIDTH;

    logic en;

    // Limit register and its scaled square.
    logic [7:0]           limit_reg;
    logic [15:0]          lim_sq_reg;
    logic [LIM_WIDTH-1:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            lim_sq_reg <= 16'(LIMIT_RESET) * 16'(LIMIT_RESET);
            lim_reg    <= LIM_WIDTH'(16'(LIMIT_RESET) * 16'(LIMIT_RESET)) *
                          LIM_WIDTH'(DANGER_SCALE);
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            lim_sq_reg <= limit_reg * limit_reg;
            lim_reg    <= LIM_WIDTH'(lim_sq_reg) * LIM_WIDTH'(DANGER_SCALE);
        end
    end

    // Stage 0: capture the sample.
    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [SW-1:0] x0_reg, y0_reg, z0_reg;

    // Stage 1: squares, sign flags, |z|.
    logic [2*SW-1:0] sqx1_reg, sqy1_reg, sqz1_reg;
    logic [2:0]      flags1_reg;
    logic            zero1_reg;
    logic [SW-1:0]   absz1_reg;

    // Stage 2: planar and total sums.
    logic [2*SW-1:0] pl2_reg, sum2_reg;
    logic [2:0]      flags2_reg;
    logic            zero2_reg;
    logic [SW-1:0]   absz2_reg;

    // Stage 3: danger compare.
    logic [2*SW-1:0] pl3_reg;
    logic [SW-1:0]   absz3_reg;
    side_t           side3_reg;

    logic signed [SW:0]     zext;
    logic signed [2*SW-1:0] sqx0, sqy0, sqz0;
    logic [CMPW-1:0]        prod_ext;

    always_comb
    begin
        zext     = {z0_reg[SW-1], z0_reg};
        sqx0     = x0_reg * x0_reg;
        sqy0     = y0_reg * y0_reg;
        sqz0     = z0_reg * z0_reg;
        prod_ext = CMPW'(sum2_reg) * CMPW'(DANGER_NUM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= s_tdata[SW-1:0];
            y0_reg <= s_tdata[16+SW-1:16];
            z0_reg <= s_tdata[32+SW-1:32];

            sqx1_reg   <= sqx0;
            sqy1_reg   <= sqy0;
            sqz1_reg   <= sqz0;
            flags1_reg <= {~z0_reg[SW-1], ~y0_reg[SW-1], ~x0_reg[SW-1]};
            zero1_reg  <= (x0_reg == '0) && (y0_reg == '0) && (z0_reg == '0);
            absz1_reg  <= zext[SW] ? SW'(-zext) : SW'(zext);

            pl2_reg    <= sqx1_reg + sqy1_reg;
            sum2_reg   <= sqx1_reg + sqy1_reg + sqz1_reg;
            flags2_reg <= flags1_reg;
            zero2_reg  <= zero1_reg;
            absz2_reg  <= absz1_reg;

            pl3_reg          <= pl2_reg;
            absz3_reg        <= absz2_reg;
            side3_reg.flags  <= flags2_reg;
            side3_reg.zero   <= zero2_reg;
            side3_reg.danger <= prod_ext > CMPW'(lim_reg);
        end
    end

    // Square root of the planar magnitude.
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [SW-1:0]   sq_absz;
    side_t           sq_side;

    tilt_isqrt #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_pl     (pl3_reg),
        .in_absz   (absz3_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_absz  (sq_absz),
        .out_side  (sq_side)
    );

    // Angle from the z axis.
    logic                        co_valid;
    logic signed [ACC_WIDTH-1:0] co_acc;
    side_t                       co_side;

    tilt_cordic #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_absz   (sq_absz),
        .in_side   (sq_side),
        .out_valid (co_valid),
        .out_acc   (co_acc),
        .out_side  (co_side)
    );

    // Degrees and characters.
    logic       dg_valid;
    side_t      dg_side;
    logic [6:0] dg_tens;
    logic [5:0] dg_ones;

    tilt_deg u_deg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (co_valid),
        .in_acc    (co_acc),
        .in_side   (co_side),
        .out_valid (dg_valid),
        .out_side  (dg_side),
        .out_tens  (dg_tens),
        .out_ones  (dg_ones)
    );

    // Output register; the pipe moves unless a finished item is blocked.
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    assign en       = m_tready || !out_valid_reg || !dg_valid;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && dg_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && dg_valid)
            out_data_reg <= {2'b00, dg_side.danger, dg_ones, dg_tens,
                             FLAG_FILL, dg_side.flags};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[tb/sv/tilt_checker.sv]
// ----------------------------------------------------------------------------
// tilt_checker
// Watches both streams of the tilt block, predicts each result from the
// accepted sample and the danger limit, and compares in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // sign_flags [7:0], tens [14:8], ones [20:15],
                                        // danger [21], zero [23:22]
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_ANGLE = 64'd3373259426;

    logic [23:0] expected_results[$];
    logic [7:0]  limit_copy;

    // Arctangent of 2^-i in Q30, truncated.
    longint atan_tab [28] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000007};

    // Bitwise integer square root.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Tilt from the z axis in whole degrees, by CORDIC vectoring.
    function automatic int tilt_degrees(longint x, longint y, longint z);
        longint unsigned planar;
        longint vx, vy, acc, ang, t;
        longint unsigned deg;
        planar = x * x + y * y;
        if (planar == 0 && z == 0)
            return 0;
        vy = int_sqrt(planar << 32);
        vx = (z < 0 ? -z : z) * 65536;
        acc = 0;
        for (int i = 0; i < 28; i++)
        begin
            if (vy >= 0)
            begin
                t = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                acc += atan_tab[i];
            end
            else
            begin
                t = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                acc -= atan_tab[i];
            end
            vx = t;
        end
        ang = (z < 0) ? PI_ANGLE - acc : acc;
        if (ang <= 0)
            return 0;
        deg = (longint'(ang) * 9000) / (longint'(157) << 30);
        if (deg > 180)
            deg = 180;
        return int'(deg);
    endfunction

    // Full packed result for one sample under a given limit.
    function automatic logic [23:0] tilt_result(logic [47:0] d, logic [7:0] lim);
        longint x, y, z;
        longint unsigned sumsq, thr;
        int deg;
        logic [7:0] flags;
        logic [6:0] tens;
        logic [5:0] ones;
        logic danger;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        flags = 8'hF8 | {5'd0, z >= 0, y >= 0, x >= 0};
        deg = tilt_degrees(x, y, z);
        tens = 7'(deg / 10 + 48);
        ones = 6'(deg % 10 + 48);
        sumsq = x * x + y * y + z * z;
        thr = longint'(lim) * longint'(lim) * 1000000;
        danger = (sumsq * 1521 > thr);
        return {2'b00, danger, ones, tens, flags};
    endfunction

    assign pending = expected_results.size();

    // Track the limit, predict on input accepts, compare on output accepts.
    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] exp_val;
        if (!rst_n)
        begin
            limit_copy <= 8'd15;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                limit_copy <= cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(tilt_result(s_tdata, limit_copy));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%t: unexpected result %h", $realtime, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_val = expected_results.pop_front();
                    if (exp_val[7:0] != m_tdata[7:0] || exp_val[14:8] != m_tdata[14:8]
                        || exp_val[20:15] != m_tdata[20:15] || exp_val[21] != m_tdata[21]
                        || exp_val[23:22] != m_tdata[23:22])
                    begin
                        $display("%t: result mismatch, expected %h, actual %h",
                                 $realtime, exp_val, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_accel_tilt_angle_danger.sv]
// ----------------------------------------------------------------------------
// tb_accel_tilt_angle_danger
// Drives directed and random acceleration samples under several danger
// limits, with random gaps on both streams; the checker judges each result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_accel_tilt_angle_danger;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          steady;

    accel_tilt_angle_danger DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata));

    tilt_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending));

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if (steady)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(8, 40);
    endfunction

    // Send one sample and hold it until accepted, then maybe pause.
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let the pipeline empty, then write the limit.
    task automatic set_limit(logic [7:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    // One random sample: full range, small, or close to one axis.
    task automatic random_sample();
        int kind;
        logic [15:0] x, y, z;
        kind = $urandom_range(0, 9);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        if (kind < 4)
        begin
            x = 16'($signed($urandom_range(0, 800)) - 400);
            y = 16'($signed($urandom_range(0, 800)) - 400);
            z = 16'($signed($urandom_range(0, 800)) - 400);
        end
        else if (kind < 6)
        begin
            x = 16'($signed($urandom_range(0, 40)) - 20);
            y = 16'($signed($urandom_range(0, 40)) - 20);
        end
        send_sample(x, y, z);
    endtask

    // Result side stalls at random, except in steady stretches.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!steady)
            begin
                m_tready <= 1'b0;
                repeat (gap_length() + 1) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no accept on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        steady    = 1'b0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples under the reset limit.
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'd0, 16'd0, 16'd256);
        send_sample(16'd0, 16'd0, 16'hFF00);
        send_sample(16'd256, 16'd0, 16'd0);
        send_sample(16'd0, 16'hFF00, 16'd0);
        send_sample(16'd100, 16'd0, 16'hFFC0);
        send_sample(16'hFFFF, 16'd1, 16'hFFFF);
        send_sample(16'd1, 16'hFFFF, 16'd1);
        send_sample(16'd384, 16'd0, 16'd0);
        send_sample(16'd385, 16'd0, 16'd0);
        send_sample(16'h5555, 16'hAAAA, 16'h00FF);
        send_sample(16'hAAAA, 16'h5555, 16'hFF00);
        send_sample(16'd0, 16'd0, 16'd1);
        send_sample(16'd0, 16'd0, 16'hFFFF);

        // Random phases across several limits, extremes among them.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: set_limit(8'd0);
                2: set_limit(8'd255);
                3: set_limit(8'd1);
                4: set_limit(8'($urandom_range(2, 254)));
                5: set_limit(8'd15);
                default: ;
            endcase
            steady = (phase == 3);
            if (phase == 2)
            begin
                send_sample(16'h8000, 16'h8000, 16'h8000);
                send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
            end
            repeat (250) random_sample();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Drain.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/tilt_pkg.sv
rtl/tilt_isqrt.sv
rtl/tilt_cordic.sv
rtl/tilt_deg.sv
rtl/accel_tilt_angle_danger.sv
tb/sv/tilt_checker.sv
tb/sv/tb_accel_tilt_angle_danger.sv
